FILE: design/wpm_pkg.sv
`default_nettype none
package wpm_pkg;

   localparam int unsigned PATTERN_MAX = 64;
   localparam int unsigned ADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

   localparam logic [7:0] SYM_STAR = 8'h2A;
   localparam logic [7:0] SYM_ANY  = 8'h3F;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_TEXT   = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic append;
      logic clear;
      logic load_sym;
      logic sweep_begin;
      logic init_step;
      logic text_step;
      logic set_started;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic started;
      logic sweep_done;
      logic rsp_full;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: design/wpm_ctrl.sv
`default_nettype none
module wpm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_op,
   input  wire logic                   rsp_stall,
   input  wire wpm_pkg::dp_status_type status,
   output wpm_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INIT = 4'b0010,
      ST_TEXT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic            pend_finish_ff, pend_finish_in;
   wpm_pkg::op_type op;
   logic            accept;

   assign op = wpm_pkg::op_type'(req_op);

   always_comb begin
      state_in       = state_ff;
      pend_finish_in = pend_finish_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      accept         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = (op == wpm_pkg::OP_FINISH) && status.rsp_full && rsp_stall;
            accept    = req_valid && !req_stall;
            if (accept) begin
               case (op)
                  wpm_pkg::OP_APPEND: cmd.append = 1'b1;
                  wpm_pkg::OP_CLEAR:  cmd.clear = 1'b1;
                  wpm_pkg::OP_TEXT: begin
                     cmd.load_sym    = 1'b1;
                     cmd.sweep_begin = 1'b1;
                     pend_finish_in  = 1'b0;
                     state_in        = status.started ? ST_TEXT : ST_INIT;
                  end
                  wpm_pkg::OP_FINISH: begin
                     if (status.started) begin
                        cmd.emit = 1'b1;
                     end else begin
                        cmd.sweep_begin = 1'b1;
                        pend_finish_in  = 1'b1;
                        state_in        = ST_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.sweep_done) begin
               cmd.set_started = 1'b1;
               if (pend_finish_ff) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.sweep_begin = 1'b1;
                  state_in        = ST_TEXT;
               end
            end
         end
         ST_TEXT: begin
            cmd.text_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_finish_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_finish_ff <= pend_finish_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/wpm_dp.sv
`default_nettype none
module wpm_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            req_symbol,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic                       rsp_matched,
   output logic                       rsp_pattern_overflow,
   input  wire wpm_pkg::dp_cmd_type   cmd,
   output wpm_pkg::dp_status_type     status
);

   logic [7:0]                  mem [0:wpm_pkg::PATTERN_MAX-1];
   logic [7:0]                  rd_ff;
   logic [wpm_pkg::CNT_W-1:0]   len_ff, len_in;
   logic [wpm_pkg::CNT_W-1:0]   j_ff, j_in;
   logic [wpm_pkg::PATTERN_MAX:0] row_ff, row_in;
   logic                        ovf_ff, ovf_in;
   logic                        started_ff, started_in;
   logic                        carry_ff, carry_in;
   logic                        prev_ff, prev_in;
   logic                        last_ff, last_in;
   logic [7:0]                  sym_ff, sym_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic len_full, j_is_zero, in_pat, is_star, sym_hit, init_bit, text_bit, new_bit, step;

   assign len_full  = (len_ff == wpm_pkg::CNT_W'(wpm_pkg::PATTERN_MAX));
   assign j_is_zero = (j_ff == '0);
   assign in_pat    = !j_is_zero && (j_ff <= len_ff);
   assign is_star   = (rd_ff == wpm_pkg::SYM_STAR);
   assign sym_hit   = (rd_ff == wpm_pkg::SYM_ANY) || (rd_ff == sym_ff);
   assign init_bit  = j_is_zero || (in_pat && carry_ff && is_star);
   assign text_bit  = in_pat && (is_star ? (carry_ff || row_ff[0]) : (prev_ff && sym_hit));
   assign new_bit   = cmd.init_step ? init_bit : text_bit;
   assign step      = cmd.init_step || cmd.text_step;

   always_comb begin
      len_in         = len_ff;
      ovf_in         = ovf_ff;
      started_in     = started_ff;
      j_in           = j_ff;
      row_in         = row_ff;
      carry_in       = carry_ff;
      prev_in        = prev_ff;
      last_in        = last_ff;
      sym_in         = sym_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.append) begin
         started_in = 1'b0;
         if (len_full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + 1'b1;
         end
      end
      if (cmd.clear) begin
         len_in     = '0;
         ovf_in     = 1'b0;
         started_in = 1'b0;
      end
      if (cmd.load_sym) begin
         sym_in = req_symbol;
      end
      if (step) begin
         row_in   = {new_bit, row_ff[wpm_pkg::PATTERN_MAX:1]};
         carry_in = new_bit;
         prev_in  = row_ff[0];
         j_in     = j_ff + 1'b1;
         if (j_ff == len_ff) begin
            last_in = new_bit;
         end
      end
      if (cmd.sweep_begin) begin
         j_in = '0;
      end
      if (cmd.set_started) begin
         started_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = last_ff;
         rsp_ovf_in     = ovf_ff;
         started_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !len_full) begin
         mem[len_ff[wpm_pkg::ADDR_W-1:0]] <= req_symbol;
      end
      rd_ff <= mem[j_ff[wpm_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      carry_ff       <= carry_in;
      prev_ff        <= prev_in;
      last_ff        <= last_in;
      sym_ff         <= sym_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   assign status.started    = started_ff;
   assign status.sweep_done = (j_ff == wpm_pkg::CNT_W'(wpm_pkg::PATTERN_MAX));
   assign status.rsp_full   = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: design/wildcard_pattern_matcher.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_stall    req_op[1:0], req_symbol[7:0]
// rsp       out        rsp_valid/rsp_stall    rsp_matched, rsp_pattern_overflow
//
// Append, clear and finish on a running text are handled in idle; a text character is taken
// in idle and then swept over all PATTERN_MAX+1 row positions: the row rotates through one
// update cell, one position per cycle. The first character or finish of each text (after reset,
// finish, append or clear) adds a PATTERN_MAX+1 position sweep to seed the row, plus an emit state for a finish.
// Reset is synchronous. The result register holds while rsp_stall is high, and a finish
// waits while a held result is still pending.
`default_nettype none
module wildcard_pattern_matcher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   wpm_pkg::dp_cmd_type    cmd;
   wpm_pkg::dp_status_type status;

   wpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wpm_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_symbol           (req_symbol),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule
`default_nettype wire
